[rtl/core/biquad_cascade_equalizer_top_assert.svh]
// assertion macros for the equaliser top level
`ifndef BIQUAD_CASCADE_EQUALIZER_TOP_ASSERT_SVH
`define BIQUAD_CASCADE_EQUALIZER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BEQ_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/core/beq_pkg.sv]
// shared types, constants and control program of the biquad equaliser
package beq_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int COEFF_BITS      = 32;
	localparam int COEFF_FRAC_BITS = 28;
	localparam int ACC_BITS        = 64;
	localparam int PROD_BITS       = COEFF_BITS + SAMPLE_BITS;
	localparam int NCOEF           = 5;
	localparam int MASK_BITS       = 8;
	localparam int ACTIVE_BITS     = 4;
	localparam int BAND_SEL_BITS   = 3;
	localparam int CSEL_BITS       = 3;
	// band counter wide enough for any band count in range
	localparam int BANDCNT_BITS    = 6;
	localparam int PC_BITS         = 4;

	localparam logic [ACC_BITS-1:0] ROUND_CONST = ACC_BITS'(1) << (COEFF_FRAC_BITS - 1);

	typedef logic [PC_BITS-1:0] pc_t;
	typedef logic [3:0][SAMPLE_BITS-1:0] delay_row_t;

	typedef enum logic [1:0] {
		MODE_FILTER = 2'd0,
		MODE_COEF   = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	typedef enum logic [CSEL_BITS-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_sel_t;

	typedef enum logic [2:0] {
		OPD_X  = 3'd0,
		OPD_D0 = 3'd1,
		OPD_D1 = 3'd2,
		OPD_D2 = 3'd3,
		OPD_D3 = 3'd4
	} opd_t;

	typedef enum logic [1:0] {
		ACC_HOLD  = 2'd0,
		ACC_CLEAR = 2'd1,
		ACC_ADD   = 2'd2,
		ACC_SUB   = 2'd3
	} acc_op_t;

	typedef enum logic [2:0] {
		COND_NEVER    = 3'd0,
		COND_ALWAYS   = 3'd1,
		COND_START    = 3'd2,
		COND_DONE     = 3'd3,
		COND_OFF      = 3'd4,
		COND_OUT_FREE = 3'd5
	} cond_t;

	typedef struct packed {
		cond_t     cond;
		pc_t       target;
		logic      hold;
		logic      coef_rd;
		coef_sel_t coef_sel;
		logic      row_rd;
		logic      mul_en;
		opd_t      opd;
		acc_op_t   acc_op;
		logic      wb;
		logic      band_inc;
		logic      out_ld;
	} ucode_t;

	typedef struct packed {
		logic start;
		logic out_free;
		logic band_done;
		logic band_off;
	} seq_stat_t;

	typedef struct packed {
		logic done;
		logic off;
	} band_stat_t;

	typedef struct packed {
		logic                       start;
		logic                       coef_wr;
		logic                       clr_all;
		logic [BAND_SEL_BITS-1:0]   band;
		logic [CSEL_BITS-1:0]       sel;
		logic [COEFF_BITS-1:0]      value;
		logic [SAMPLE_BITS-1:0]     sample;
	} dp_cmd_t;

	localparam pc_t PC_IDLE  = 4'd0;
	localparam pc_t PC_CHECK = 4'd1;
	localparam pc_t PC_TEST  = 4'd2;
	localparam pc_t PC_MUL0  = 4'd3;
	localparam pc_t PC_MUL1  = 4'd4;
	localparam pc_t PC_MUL2  = 4'd5;
	localparam pc_t PC_MUL3  = 4'd6;
	localparam pc_t PC_MUL4  = 4'd7;
	localparam pc_t PC_ACC4  = 4'd8;
	localparam pc_t PC_WB    = 4'd9;
	localparam pc_t PC_SKIP  = 4'd10;
	localparam pc_t PC_FIN   = 4'd11;

	localparam ucode_t UC_NOP = '{
		cond: COND_NEVER, target: PC_IDLE, hold: 1'b0, coef_rd: 1'b0,
		coef_sel: COEF_B0, row_rd: 1'b0, mul_en: 1'b0, opd: OPD_X,
		acc_op: ACC_HOLD, wb: 1'b0, band_inc: 1'b0, out_ld: 1'b0
	};

	// control store: one word per step
	function automatic ucode_t ucode(input pc_t pc);
		ucode_t w;
		w = UC_NOP;
		case (pc)
			PC_IDLE: begin
				w.cond = COND_START; w.target = PC_CHECK; w.hold = 1'b1;
			end
			PC_CHECK: begin
				w.cond = COND_DONE; w.target = PC_FIN;
			end
			PC_TEST: begin
				w.cond = COND_OFF; w.target = PC_SKIP;
				w.coef_rd = 1'b1; w.coef_sel = COEF_B0;
				w.row_rd = 1'b1; w.acc_op = ACC_CLEAR;
			end
			PC_MUL0: begin
				w.coef_rd = 1'b1; w.coef_sel = COEF_B1;
				w.mul_en = 1'b1; w.opd = OPD_X;
			end
			PC_MUL1: begin
				w.coef_rd = 1'b1; w.coef_sel = COEF_B2;
				w.mul_en = 1'b1; w.opd = OPD_D0; w.acc_op = ACC_ADD;
			end
			PC_MUL2: begin
				w.coef_rd = 1'b1; w.coef_sel = COEF_A1;
				w.mul_en = 1'b1; w.opd = OPD_D1; w.acc_op = ACC_ADD;
			end
			PC_MUL3: begin
				w.coef_rd = 1'b1; w.coef_sel = COEF_A2;
				w.mul_en = 1'b1; w.opd = OPD_D2; w.acc_op = ACC_ADD;
			end
			PC_MUL4: begin
				w.mul_en = 1'b1; w.opd = OPD_D3; w.acc_op = ACC_SUB;
			end
			PC_ACC4: begin
				w.acc_op = ACC_SUB;
			end
			PC_WB: begin
				w.wb = 1'b1; w.band_inc = 1'b1;
				w.cond = COND_ALWAYS; w.target = PC_CHECK;
			end
			PC_SKIP: begin
				w.band_inc = 1'b1;
				w.cond = COND_ALWAYS; w.target = PC_CHECK;
			end
			PC_FIN: begin
				w.out_ld = 1'b1; w.cond = COND_OUT_FREE; w.target = PC_IDLE;
				w.hold = 1'b1;
			end
			default: begin
				w.cond = COND_ALWAYS; w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

[rtl/core/beq_sequencer.sv]
// step counter and control store of the equaliser
module beq_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  beq_pkg::seq_stat_t  stat,
	output beq_pkg::ucode_t     uw,
	output logic                idle,
	output logic                finish
);
	import beq_pkg::*;

	pc_t  pc_q;
	pc_t  pc_d;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		uw = ucode(pc_q);
		case (uw.cond)
			COND_ALWAYS:   take = 1'b1;
			COND_START:    take = stat.start;
			COND_DONE:     take = stat.band_done;
			COND_OFF:      take = stat.band_off;
			COND_OUT_FREE: take = stat.out_free;
			default:       take = 1'b0;
		endcase
		if (take) begin
			pc_d = uw.target;
		end else if (uw.hold) begin
			pc_d = pc_q;
		end else begin
			pc_d = pc_q + 1'b1;
		end
		idle   = (pc_q == PC_IDLE);
		finish = uw.out_ld && take;
	end

endmodule

[rtl/core/beq_datapath.sv]
// coefficient and delay memories, shared multiplier, accumulator and saturation
module beq_datapath #(
	parameter int MAX_BANDS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  beq_pkg::ucode_t                       uw,
	input  beq_pkg::dp_cmd_t                      cmd,
	input  logic [beq_pkg::ACTIVE_BITS-1:0]       active_bands,
	input  logic [beq_pkg::MASK_BITS-1:0]         band_enable_mask,
	output beq_pkg::band_stat_t                   bstat,
	output logic [beq_pkg::SAMPLE_BITS-1:0]       y_out,
	output logic                                  clip_out
);
	import beq_pkg::*;

	localparam int BAND_W   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
	localparam int NCOEF_EN = MAX_BANDS * NCOEF;
	localparam int CADDR_W  = $clog2(NCOEF_EN);
	localparam int SH_BITS  = ACC_BITS - COEFF_FRAC_BITS;

	localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [COEFF_BITS-1:0]    coef_mem [NCOEF_EN];
	logic [NCOEF_EN-1:0]      coef_vld_q;
	logic [COEFF_BITS-1:0]    coef_rd_q;
	logic                     coef_rv_q;

	delay_row_t               row_mem [MAX_BANDS];
	logic [MAX_BANDS-1:0]     row_vld_q;
	delay_row_t               row_rd_q;
	logic                     row_rv_q;

	logic [PROD_BITS-1:0]     prod_q;
	logic [ACC_BITS-1:0]      acc_q;
	logic [SAMPLE_BITS-1:0]   x_q;
	logic [BANDCNT_BITS-1:0]  band_q;
	logic                     clip_q;

	logic                     coef_ok;
	logic [8:0]               cw_full;
	logic [8:0]               cr_full;
	logic [CADDR_W-1:0]       caddr_w;
	logic [CADDR_W-1:0]       caddr_r;
	logic [BANDCNT_BITS-1:0]  wband;
	logic [BANDCNT_BITS-1:0]  ab_ext;
	logic [BANDCNT_BITS-1:0]  n_eff;
	logic [COEFF_BITS-1:0]    coef_eff;
	delay_row_t               row_eff;
	delay_row_t               row_new;
	logic [SAMPLE_BITS-1:0]   opnd;
	logic [ACC_BITS-1:0]      prod_ext;
	logic [SH_BITS-1:0]       sh;
	logic [SH_BITS-SAMPLE_BITS:0] sh_top;
	logic                     in_range;
	logic [SAMPLE_BITS-1:0]   y;

	always_comb begin
		// coefficient address band*5 + index
		cw_full = ({6'b0, cmd.band} << 2) + {6'b0, cmd.band} + {6'b0, cmd.sel};
		cr_full = ({3'b0, band_q} << 2) + {3'b0, band_q} + {6'b0, uw.coef_sel};
		caddr_w = CADDR_W'(cw_full);
		caddr_r = CADDR_W'(cr_full);
		wband   = BANDCNT_BITS'(cmd.band);
		coef_ok = cmd.coef_wr && (wband < BANDCNT_BITS'(MAX_BANDS))
			&& (cmd.sel < CSEL_BITS'(NCOEF));

		ab_ext = BANDCNT_BITS'(active_bands);
		n_eff  = (ab_ext > BANDCNT_BITS'(MAX_BANDS)) ? BANDCNT_BITS'(MAX_BANDS) : ab_ext;
		bstat.done = (band_q >= n_eff);
		// only the first eight bands have an enable bit
		bstat.off  = !((band_q < BANDCNT_BITS'(MASK_BITS)) && band_enable_mask[band_q[2:0]]);

		coef_eff = coef_rv_q ? coef_rd_q : '0;
		row_eff  = row_rv_q ? row_rd_q : '0;

		case (uw.opd)
			OPD_X:   opnd = x_q;
			OPD_D0:  opnd = row_eff[0];
			OPD_D1:  opnd = row_eff[1];
			OPD_D2:  opnd = row_eff[2];
			OPD_D3:  opnd = row_eff[3];
			default: opnd = x_q;
		endcase

		prod_ext = {{(ACC_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};

		// accumulator already carries the rounding half
		sh       = acc_q[ACC_BITS-1:COEFF_FRAC_BITS];
		sh_top   = sh[SH_BITS-1:SAMPLE_BITS-1];
		in_range = (&sh_top) || !(|sh_top);
		if (in_range) begin
			y = sh[SAMPLE_BITS-1:0];
		end else if (sh[SH_BITS-1]) begin
			y = SAT_MIN;
		end else begin
			y = SAT_MAX;
		end

		row_new[0] = x_q;
		row_new[1] = row_eff[0];
		row_new[2] = y;
		row_new[3] = row_eff[2];

		y_out    = x_q;
		clip_out = clip_q;
	end

	// memory arrays
	always_ff @(posedge clk) begin
		if (coef_ok) begin
			coef_mem[caddr_w] <= cmd.value;
		end
		if (uw.coef_rd) begin
			coef_rd_q <= coef_mem[caddr_r];
		end
	end

	always_ff @(posedge clk) begin
		if (uw.wb) begin
			row_mem[band_q[BAND_W-1:0]] <= row_new;
		end
		if (uw.row_rd) begin
			row_rd_q <= row_mem[band_q[BAND_W-1:0]];
		end
	end

	// entry valid bits stand in for the all-zero reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			row_vld_q  <= '0;
			coef_rv_q  <= 1'b0;
			row_rv_q   <= 1'b0;
		end else begin
			if (coef_ok) begin
				coef_vld_q[caddr_w]          <= 1'b1;
				row_vld_q[wband[BAND_W-1:0]] <= 1'b0;
			end
			if (cmd.clr_all) begin
				row_vld_q <= '0;
			end
			if (uw.wb) begin
				row_vld_q[band_q[BAND_W-1:0]] <= 1'b1;
			end
			if (uw.coef_rd) begin
				coef_rv_q <= coef_vld_q[caddr_r];
			end
			if (uw.row_rd) begin
				row_rv_q <= row_vld_q[band_q[BAND_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= '0;
			clip_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				band_q <= '0;
				clip_q <= 1'b0;
			end else begin
				if (uw.band_inc) begin
					band_q <= band_q + 1'b1;
				end
				if (uw.wb && !in_range) begin
					clip_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= cmd.sample;
		end else if (uw.wb) begin
			x_q <= y;
		end
		if (uw.mul_en) begin
			prod_q <= PROD_BITS'($signed(coef_eff) * $signed(opnd));
		end
		case (uw.acc_op)
			ACC_CLEAR: acc_q <= ROUND_CONST;
			ACC_ADD:   acc_q <= acc_q + prod_ext;
			ACC_SUB:   acc_q <= acc_q - prod_ext;
			default:   acc_q <= acc_q;
		endcase
	end

endmodule

[rtl/core/biquad_cascade_equalizer_top.sv]
// top level of the cascaded biquad equaliser: handshakes, register port, result register
// A filter item (mode 0) runs the sample through up to eight direct-form-I biquad
// sections on one shared 32x24 multiplier, five products per section. After the
// accepting edge in_stall stays high until the sequencer is back in its idle step,
// so a new filter item is taken only once the last one has passed every section
// within active_bands: the control program steps the single multiplier and
// accumulator through the products of each enabled section, skips each disabled
// one, and holds in its last step while an earlier result still waits unread in
// the output register. Coefficient writes (mode 1) and delay-line clears (mode 2)
// complete at the accepting edge and produce no result, so the next item may
// follow in the next cycle. A finished result waits in the output register while
// the next item is taken; a section clipped to 24 bits sets saturated.
// Coefficient and delay memories read as zero after reset until written.
`include "biquad_cascade_equalizer_top_assert.svh"

module biquad_cascade_equalizer_top #(
	parameter int MAX_BANDS = 8
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_stall,
	input  logic [1:0]                                   mode,
	input  logic signed [beq_pkg::SAMPLE_BITS-1:0]       sample_in,
	input  logic [beq_pkg::BAND_SEL_BITS-1:0]            band_select,
	input  logic [beq_pkg::CSEL_BITS-1:0]                coeff_select,
	input  logic signed [beq_pkg::COEFF_BITS-1:0]        coeff_value,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic signed [beq_pkg::SAMPLE_BITS-1:0]       sample_out,
	output logic                                         saturated,
	input  logic                                         psel,
	input  logic                                         penable,
	input  logic                                         pwrite,
	input  logic [2:0]                                   paddr,
	input  logic [31:0]                                  pwdata,
	output logic [31:0]                                  prdata,
	output logic                                         pready
);
	import beq_pkg::*;

	localparam logic REG_ACTIVE_BANDS = 1'b0;
	localparam logic REG_BAND_MASK    = 1'b1;

	logic [ACTIVE_BITS-1:0]  active_bands_q;
	logic [MASK_BITS-1:0]    mask_q;
	logic                    out_valid_q;
	logic [SAMPLE_BITS-1:0]  sample_out_q;
	logic                    saturated_q;

	logic                    accept;
	logic                    cfg_wr;
	logic                    reg_idx;
	seq_stat_t               seq_stat;
	ucode_t                  uw;
	logic                    seq_idle;
	logic                    seq_finish;
	dp_cmd_t                 cmd;
	band_stat_t              bstat;
	logic [SAMPLE_BITS-1:0]  dp_y;
	logic                    dp_clip;

	beq_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (seq_stat),
		.uw     (uw),
		.idle   (seq_idle),
		.finish (seq_finish)
	);

	beq_datapath #(
		.MAX_BANDS (MAX_BANDS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.uw               (uw),
		.cmd              (cmd),
		.active_bands     (active_bands_q),
		.band_enable_mask (mask_q),
		.bstat            (bstat),
		.y_out            (dp_y),
		.clip_out         (dp_clip)
	);

	always_comb begin
		in_stall = !seq_idle;
		accept   = in_valid && !in_stall;

		cmd.start   = accept && (mode == MODE_FILTER);
		cmd.coef_wr = accept && (mode == MODE_COEF);
		cmd.clr_all = accept && (mode == MODE_CLEAR);
		cmd.band    = band_select;
		cmd.sel     = coeff_select;
		cmd.value   = coeff_value;
		cmd.sample  = sample_in;

		seq_stat.start     = cmd.start;
		seq_stat.out_free  = !out_valid_q || !out_stall;
		seq_stat.band_done = bstat.done;
		seq_stat.band_off  = bstat.off;

		out_valid  = out_valid_q;
		sample_out = sample_out_q;
		saturated  = saturated_q;

		pready  = 1'b1;
		cfg_wr  = psel && penable && pwrite && pready;
		reg_idx = paddr[2];
		case (reg_idx)
			REG_ACTIVE_BANDS: prdata = 32'(active_bands_q);
			REG_BAND_MASK:    prdata = 32'(mask_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bands_q <= '0;
			mask_q         <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ACTIVE_BANDS: active_bands_q <= pwdata[ACTIVE_BITS-1:0];
				REG_BAND_MASK:    mask_q         <= pwdata[MASK_BITS-1:0];
				default:          mask_q         <= mask_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_finish) begin
			sample_out_q <= dp_y;
			saturated_q  <= dp_clip;
		end
	end

	`BEQ_ASSERT_NEXT(a_start_leaves_idle, seq_stat.start, !seq_idle, "sequencer stayed idle after a filter item")
	`BEQ_ASSERT_NOW(a_no_overwrite, seq_finish, !out_valid_q || !out_stall, "result register overwritten while held")
	`BEQ_ASSERT_NEXT(a_no_spurious, !out_valid_q && !seq_finish, !out_valid_q, "result appeared without a finished item")

endmodule

[verif/tb_biquad_cascade_equalizer_top.sv]
// self-checking testbench of the cascaded biquad equaliser: directed table, then random phases
module tb_biquad_cascade_equalizer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import beq_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int BANDS         = 8;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 100;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_ITEMS   = 52;
	localparam int DIR_ROWS      = 28;
	localparam int MAX_SHOWN     = 10;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [CSEL_BITS-1:0] CSEL_GAP = CSEL_BITS'(NCOEF);
	localparam logic [CSEL_BITS-1:0] CSEL_TOP = '1;
	localparam logic [2:0] REG_BANDS = 3'd0;
	localparam logic [2:0] REG_MASK  = 3'd4;

	// delay line slots of one band
	localparam int DX1 = 0;
	localparam int DX2 = 1;
	localparam int DY1 = 2;
	localparam int DY2 = 3;

	localparam logic signed [SAMPLE_BITS-1:0] SMP_HI = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_LO = 24'sh800000;
	localparam logic signed [COEFF_BITS-1:0] UNITY = 32'sh1000_0000;
	localparam longint RND    = longint'(1) <<< (COEFF_FRAC_BITS - 1);
	localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct packed {
		logic [1:0]                    md;
		logic signed [SAMPLE_BITS-1:0] smp;
		logic [BAND_SEL_BITS-1:0]      band;
		logic [CSEL_BITS-1:0]          csel;
		logic signed [COEFF_BITS-1:0]  cval;
	} eq_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] smp;
		logic                          sat;
	} eq_result_t;

	typedef struct packed {
		logic                          is_cfg;
		logic [3:0]                    nb;
		logic [7:0]                    mask;
		eq_item_t                      it;
		logic                          typed;
		logic signed [SAMPLE_BITS-1:0] t_smp;
		logic                          t_sat;
	} tab_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] mode;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [BAND_SEL_BITS-1:0] band_select;
	logic [CSEL_BITS-1:0] coeff_select;
	logic signed [COEFF_BITS-1:0] coeff_value;
	logic out_valid;
	logic out_stall;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic saturated;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// shadow of the block state
	logic [3:0] cfg_bands;
	logic [7:0] cfg_mask;
	logic signed [COEFF_BITS-1:0] coef_mem [BANDS*NCOEF];
	logic signed [SAMPLE_BITS-1:0] dly_mem [BANDS][4];

	eq_result_t due_samples [$];
	int mismatches = 0;
	int cycle_count = 0;
	bit calm = 1'b0;

	biquad_cascade_equalizer_top #(.MAX_BANDS(BANDS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .sample_in(sample_in), .band_select(band_select),
		.coeff_select(coeff_select), .coeff_value(coeff_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample_out(sample_out), .saturated(saturated),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	function automatic void equalise_item(input eq_item_t it, output logic has_res,
			output eq_result_t res);
		longint acc;
		longint x;
		longint y;
		int b;
		int nb;
		int base;
		logic clip;
		has_res = 1'b0;
		res = '0;
		case (it.md)
			MODE_FILTER: begin
				clip = 1'b0;
				x = longint'(it.smp);
				nb = (cfg_bands > BANDS) ? BANDS : int'(cfg_bands);
				for (b = 0; b < nb; b++) begin
					// a bypassed band keeps its delay line as it is
					if (cfg_mask[b]) begin
						base = b * NCOEF;
						acc = longint'(coef_mem[base + COEF_B0]) * x
							+ longint'(coef_mem[base + COEF_B1]) * longint'(dly_mem[b][DX1])
							+ longint'(coef_mem[base + COEF_B2]) * longint'(dly_mem[b][DX2])
							- longint'(coef_mem[base + COEF_A1]) * longint'(dly_mem[b][DY1])
							- longint'(coef_mem[base + COEF_A2]) * longint'(dly_mem[b][DY2]);
						y = (acc + RND) >>> COEFF_FRAC_BITS;
						if (y > SAT_HI) begin
							y = SAT_HI;
							clip = 1'b1;
						end
						if (y < SAT_LO) begin
							y = SAT_LO;
							clip = 1'b1;
						end
						dly_mem[b][DX2] = dly_mem[b][DX1];
						dly_mem[b][DX1] = x[SAMPLE_BITS-1:0];
						dly_mem[b][DY2] = dly_mem[b][DY1];
						dly_mem[b][DY1] = y[SAMPLE_BITS-1:0];
						x = y;
					end
				end
				res.smp = x[SAMPLE_BITS-1:0];
				res.sat = clip;
				has_res = 1'b1;
			end
			MODE_COEF: begin
				// out-of-range coefficient index leaves everything alone
				if (it.csel < NCOEF) begin
					coef_mem[it.band * NCOEF + it.csel] = it.cval;
					for (b = 0; b < 4; b++) dly_mem[it.band][b] = '0;
				end
			end
			MODE_CLEAR: begin
				foreach (dly_mem[i, j]) dly_mem[i][j] = '0;
			end
			default: ;
		endcase
	endfunction

	function automatic eq_item_t mk(input logic [1:0] md, input logic signed [SAMPLE_BITS-1:0] smp,
			input logic [BAND_SEL_BITS-1:0] band, input logic [CSEL_BITS-1:0] csel,
			input logic signed [COEFF_BITS-1:0] cval);
		eq_item_t it;
		it.md = md;
		it.smp = smp;
		it.band = band;
		it.csel = csel;
		it.cval = cval;
		return it;
	endfunction

	function automatic tab_row_t r_item(input logic [1:0] md,
			input logic signed [SAMPLE_BITS-1:0] smp, input logic [BAND_SEL_BITS-1:0] band,
			input logic [CSEL_BITS-1:0] csel, input logic signed [COEFF_BITS-1:0] cval);
		tab_row_t r;
		r = '0;
		r.it = mk(md, smp, band, csel, cval);
		return r;
	endfunction

	function automatic tab_row_t r_known(input logic signed [SAMPLE_BITS-1:0] smp,
			input logic signed [SAMPLE_BITS-1:0] t_smp, input logic t_sat);
		tab_row_t r;
		r = '0;
		r.it = mk(MODE_FILTER, smp, '0, COEF_B0, '0);
		r.typed = 1'b1;
		r.t_smp = t_smp;
		r.t_sat = t_sat;
		return r;
	endfunction

	function automatic tab_row_t r_cfg(input logic [3:0] nb, input logic [7:0] mask);
		tab_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.nb = nb;
		r.mask = mask;
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return SMP_HI;
			1: return SMP_LO;
			2: return SAMPLE_BITS'($signed($urandom_range(0, 511)) - 256);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic signed [COEFF_BITS-1:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return COEFF_BITS'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return '0;
					default: return UNITY;
				endcase
			end
			// mostly within a few units so the cascade stays in a useful range
			default: return $signed($urandom) >>> $urandom_range(2, 5);
		endcase
	endfunction

	task automatic send_item(input eq_item_t it, input logic typed,
			input logic signed [SAMPLE_BITS-1:0] t_smp, input logic t_sat);
		int gap;
		logic has_res;
		eq_result_t res;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.md;
		sample_in <= it.smp;
		band_select <= it.band;
		coeff_select <= it.csel;
		coeff_value <= it.cval;
		do @(posedge clk); while (in_stall);
		equalise_item(it, has_res, res);
		if (has_res) begin
			if (typed) begin
				res.smp = t_smp;
				res.sat = t_sat;
			end
			due_samples.push_back(res);
		end
	endtask

	task automatic program_band(input int b);
		int s;
		for (s = 0; s < NCOEF; s++)
			send_item(mk(MODE_COEF, rand_sample(), BAND_SEL_BITS'(b), CSEL_BITS'(s), rand_coef()),
				1'b0, '0, 1'b0);
	endtask

	// leaves psel high so that a following write can start in the next cycle
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (addr)
			REG_BANDS: cfg_bands = data[3:0];
			REG_MASK: cfg_mask = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [3:0] nb, input logic [7:0] msk);
		reg_write(REG_BANDS, 32'(nb));
		reg_write(REG_MASK, 32'(msk));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always begin : result_sink
		int hold;
		hold = calm ? 0 : $urandom_range(0, 12);
		if (hold > 0) begin
			out_stall <= 1'b1;
			// hold either from the last item or from the moment a result shows up
			if ($urandom_range(0, 1) == 1) begin
				do @(posedge clk); while (!out_valid);
			end
			repeat (hold) @(posedge clk);
		end
		out_stall <= 1'b0;
		do @(posedge clk); while (!out_valid);
	end

	always @(posedge clk) begin : result_check
		eq_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result: sample_out %0d saturated %0b",
						sample_out, saturated);
			end else begin
				want = due_samples.pop_front();
				if (sample_out !== want.smp || saturated !== want.sat) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch: want %0d sat %0b, got %0d sat %0b",
							want.smp, want.sat, sample_out, saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_biquad_cascade_equalizer_top: errors");
			$finish;
		end
	end

	initial begin : run
		tab_row_t dir_tab [DIR_ROWS];
		int i;
		int p;
		int k;
		int pick;
		logic [3:0] nb;
		logic [7:0] msk;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_FILTER;
		sample_in <= '0;
		band_select <= '0;
		coeff_select <= COEF_B0;
		coeff_value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg_bands = '0;
		cfg_mask = '0;
		foreach (coef_mem[j]) coef_mem[j] = '0;
		foreach (dly_mem[j, m]) dly_mem[j][m] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		dir_tab = '{
			// no bands after reset: samples pass straight through
			r_known(SMP_HI, SMP_HI, 1'b0),
			r_known(SMP_LO, SMP_LO, 1'b0),
			r_known('0, '0, 1'b0),
			r_item(MODE_UNUSED, SMP_HI, '1, CSEL_TOP, '1),
			r_item(MODE_CLEAR, SMP_LO, '1, CSEL_TOP, '1),
			r_item(MODE_COEF, '0, 3'd0, COEF_B0, UNITY),
			// coefficient index out of range, ignored
			r_item(MODE_COEF, SMP_HI, 3'd3, CSEL_GAP, 32'sh7FFF_FFFF),
			r_item(MODE_COEF, SMP_LO, 3'd7, CSEL_TOP, '1),
			r_cfg(4'd1, 8'h01),
			r_item(MODE_FILTER, SMP_HI, '0, COEF_B0, '0),
			r_item(MODE_FILTER, 24'sh123456, '0, COEF_B0, '0),
			r_item(MODE_COEF, '0, 3'd0, COEF_B0, 32'sh7FFF_FFFF),
			r_known(SMP_HI, SMP_HI, 1'b1),
			r_known(SMP_LO, SMP_LO, 1'b1),
			r_item(MODE_COEF, '0, 3'd0, COEF_B0, 32'sh8000_0000),
			r_known(SMP_HI, SMP_LO, 1'b1),
			// band 0 becomes an integrator
			r_item(MODE_COEF, '0, 3'd0, COEF_B0, UNITY),
			r_item(MODE_COEF, '0, 3'd0, COEF_A1, -UNITY),
			r_cfg(4'd1, 8'h00),
			r_known(24'sh2AAAAA, 24'sh2AAAAA, 1'b0),
			// band count above the maximum
			r_cfg(4'd15, 8'hFF),
			r_item(MODE_FILTER, 24'sh400000, '0, COEF_B0, '0),
			r_cfg(4'd8, 8'h01),
			r_item(MODE_FILTER, 24'sh300000, '0, COEF_B0, '0),
			r_item(MODE_FILTER, 24'sh300000, '0, COEF_B0, '0),
			r_item(MODE_FILTER, 24'sh300000, '0, COEF_B0, '0),
			r_item(MODE_CLEAR, '0, '0, COEF_B0, '0),
			r_item(MODE_FILTER, 24'sh300000, '0, COEF_B0, '0)
		};
		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].is_cfg) begin
				drain();
				set_config(dir_tab[i].nb, dir_tab[i].mask);
			end else begin
				send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].t_smp, dir_tab[i].t_sat);
			end
		end

		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin nb = 4'(BANDS); msk = 8'hFF; end
				1: begin nb = 4'd15; msk = 8'hFF; end
				2: begin nb = 4'd0; msk = 8'($urandom); end
				3: begin nb = 4'(BANDS); msk = 8'h00; end
				4: begin nb = 4'd1; msk = 8'h01; end
				default: begin nb = 4'($urandom_range(0, 15)); msk = 8'($urandom); end
			endcase
			drain();
			set_config(nb, msk);
			// no idling on either side in phase 6 and in about one other phase in five
			calm = (p == 6) || ($urandom_range(0, 4) == 0);
			if (p == 0) begin
				for (k = 0; k < BANDS; k++) program_band(k);
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					send_item(mk(MODE_FILTER, rand_sample(), BAND_SEL_BITS'($urandom),
						CSEL_BITS'($urandom), COEFF_BITS'($urandom)), 1'b0, '0, 1'b0);
				else if (pick < 78)
					program_band($urandom_range(0, BANDS - 1));
				else if (pick < 84)
					send_item(mk(MODE_COEF, rand_sample(), BAND_SEL_BITS'($urandom),
						CSEL_BITS'($urandom_range(0, NCOEF - 1)), rand_coef()), 1'b0, '0, 1'b0);
				else if (pick < 88)
					send_item(mk(MODE_COEF, rand_sample(), BAND_SEL_BITS'($urandom),
						CSEL_BITS'($urandom_range(NCOEF, 7)), COEFF_BITS'($urandom)),
						1'b0, '0, 1'b0);
				else if (pick < 93)
					send_item(mk(MODE_CLEAR, rand_sample(), BAND_SEL_BITS'($urandom),
						CSEL_BITS'($urandom), COEFF_BITS'($urandom)), 1'b0, '0, 1'b0);
				else
					send_item(mk(MODE_UNUSED, rand_sample(), BAND_SEL_BITS'($urandom),
						CSEL_BITS'($urandom), COEFF_BITS'($urandom)), 1'b0, '0, 1'b0);
			end
		end

		drain();
		if (mismatches == 0)
			$display("tb_biquad_cascade_equalizer_top: clean");
		else
			$display("tb_biquad_cascade_equalizer_top: errors");
		$finish;
	end

endmodule
